// ----- rtl/core/aco_pkg.sv -----
// ----------------------------------------------------------------------------
// aco_pkg
// Shared types, sizes and helpers for the oldest-replace address cache.
// ----------------------------------------------------------------------------
package aco_pkg;

	localparam int ENTRIES  = 16;                        // cache entries, 2..256
	localparam int IDX_W    = $clog2(ENTRIES);           // entry number width
	localparam int PAD      = 1 << IDX_W;                // entries rounded up to 2^n
	localparam int SLOT_W   = 4;                         // reported slot width
	localparam int SETTLE   = IDX_W / 2;                 // registered levels of age tree
	localparam int SETTLE_W = (SETTLE < 1) ? 1 : $clog2(SETTLE + 1);

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] proto_addr;
		logic [47:0] hw_addr;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] hw_addr_out;
		logic [SLOT_W-1:0] slot_index;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture incoming request
		logic commit;   // resolve request, update entries, load result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic insert;   // held request is an insert
	} dp_stat_t;

	// entry number to reported slot (low bits, zero extended when narrow)
	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] w;
		w = {{SLOT_W{1'b0}}, idx};
		return w[SLOT_W-1:0];
	endfunction

endpackage

// ----- rtl/core/aco_ctrl.sv -----
// ----------------------------------------------------------------------------
// aco_ctrl
// Request sequencer: input handshake, result register valid, and the wait
// for the age tree to settle after an entry write.
// ----------------------------------------------------------------------------
module aco_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  aco_pkg::dp_stat_t   stat,
	output aco_pkg::dp_cmd_t    cmd
);
	import aco_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	state_t              state_q;
	logic                rsp_valid_q;
	logic [SETTLE_W-1:0] settle_q;
	logic                slot_free;
	logic                go;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// result register can take a new result this cycle
	assign slot_free = !rsp_valid_q || !rsp_stall;
	// inserts need the oldest-entry search to reflect the last write
	assign go = (state_q == S_EVAL) && slot_free &&
		(!stat.insert || (settle_q == '0));

	assign cmd.load   = (state_q == S_IDLE) && req_valid;
	assign cmd.commit = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			settle_q    <= '0;
		end else begin
			if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (go && stat.insert) begin
				settle_q <= SETTLE_W'(SETTLE);
			end

			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/aco_datapath.sv -----
// ----------------------------------------------------------------------------
// aco_datapath
// Entry store, parallel key match, free-entry search, registered age tree
// and result register.
// ----------------------------------------------------------------------------
module aco_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  aco_pkg::req_t     req,
	input  aco_pkg::dp_cmd_t  cmd,
	output aco_pkg::dp_stat_t stat,
	output aco_pkg::rsp_t     rsp
);
	import aco_pkg::*;

	typedef struct packed {
		logic [31:0]      t;
		logic [IDX_W-1:0] idx;
	} cand_t;

	req_t             req_q;
	rsp_t             rsp_q;

	logic [ENTRIES-1:0] entry_valid_q;
	logic [31:0]        entry_key_q  [ENTRIES];
	logic [47:0]        entry_hw_q   [ENTRIES];
	logic [31:0]        entry_time_q [ENTRIES];

	logic [ENTRIES-1:0] match;
	logic               hit;
	logic               any_free;
	logic [IDX_W-1:0]   match_idx;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   victim_idx;
	logic [IDX_W-1:0]   slot;
	logic [47:0]        hit_hw;
	logic               is_insert;

	cand_t node [IDX_W+1][PAD];

	assign is_insert   = (req_q.action == ACT_INSERT);
	assign stat.insert = is_insert;
	assign rsp         = rsp_q;

	// request holding register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// --- age tree: leaves are entry times, padding leaves never win ---
	genvar gi, gk, gj;
	for (gi = 0; gi < PAD; gi++) begin : g_leaf
		if (gi < ENTRIES) begin : g_real
			assign node[0][gi] = '{t: entry_time_q[gi], idx: IDX_W'(gi)};
		end else begin : g_pad
			assign node[0][gi] = '{t: '1, idx: IDX_W'(gi)};
		end
	end

	for (gk = 1; gk <= IDX_W; gk++) begin : g_lvl
		for (gj = 0; gj < (PAD >> gk); gj++) begin : g_node
			cand_t win;
			// strictly older on the right wins, ties keep the lower index
			assign win = (node[gk-1][2*gj+1].t < node[gk-1][2*gj].t) ?
				node[gk-1][2*gj+1] : node[gk-1][2*gj];
			if ((gk % 2) == 0) begin : g_reg
				cand_t win_q;
				always_ff @(posedge clk) begin
					win_q <= win;
				end
				assign node[gk][gj] = win_q;
			end else begin : g_comb
				assign node[gk][gj] = win;
			end
		end
	end

	assign victim_idx = node[IDX_W][0].idx;

	// --- match and free search ---
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = entry_valid_q[i] && (entry_key_q[i] == req_q.proto_addr);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_idx = IDX_W'(i);
			end
			if (!entry_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		hit      = |match;
		any_free = !(&entry_valid_q);
		hit_hw   = entry_hw_q[match_idx];
		if (hit) begin
			slot = match_idx;
		end else if (any_free) begin
			slot = free_idx;
		end else begin
			slot = victim_idx;
		end
	end

	// --- entry store ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (cmd.commit && is_insert) begin
			entry_valid_q[slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && is_insert) begin
			entry_key_q[slot]  <= req_q.proto_addr;
			entry_hw_q[slot]   <= req_q.hw_addr;
			entry_time_q[slot] <= req_q.now_time;
		end
	end

	// --- result register ---
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.hit         <= hit;
			rsp_q.hw_addr_out <= (!is_insert && hit) ? hit_hw : 48'd0;
			rsp_q.slot_index  <= (is_insert || hit) ? to_slot(slot) : '0;
		end
	end

endmodule

// ----- rtl/core/address_cache_oldest_replace.sv -----
// ----------------------------------------------------------------------------
// address_cache_oldest_replace
// Fully associative protocol-to-hardware address cache, oldest-entry
// replacement.
// ----------------------------------------------------------------------------
// Sixteen entries map a 32-bit protocol address to a 48-bit hardware address
// with an insertion time. A lookup request (action 0) returns hit, the stored
// hardware address and the matching slot; a miss returns all zeros. An insert
// request (action 1) refreshes the entry holding the key, else takes the
// lowest free entry, else the entry with the smallest time (lowest index on
// ties); it returns hit (key was present) and the slot written. Times compare
// as plain unsigned values, so wrap is not handled. Each request is first
// captured, then all keys are matched in parallel and it commits once the
// output register can take the result. An insert waits while the
// registered oldest-entry tree (two register levels, a compare per level)
// catches up with an earlier insert's write; lookups never wait for it. A new
// request is taken while a finished result is still stalled in the output
// register. Entries are invalid after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module address_cache_oldest_replace (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  aco_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output aco_pkg::rsp_t rsp
);
	import aco_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: handshake, result valid, settle wait
	aco_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// entries, match, replacement choice, result register
	aco_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
